### design/ntc_pkg.sv
// Package: shared types, constants and the resistance/temperature table.
package ntc_pkg;
	localparam int TABLE_ENTRIES = 39;
	localparam int FRAC_BITS = 8;
	localparam int RES_INT_BITS = 20;
	localparam int RES_W = RES_INT_BITS + FRAC_BITS;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int NUM_W = 36 + FRAC_BITS;
	localparam int QCNT_W = $clog2(NUM_W + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ABOVE = 2'd1;
	localparam logic [1:0] ST_BELOW = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	localparam logic signed [15:0] T_HIGH_MARK = 16'sd32767;
	localparam logic signed [15:0] T_LOW_MARK = -16'sd32768;

	localparam logic [1:0] REG_SUPPLY = 2'd0;
	localparam logic [1:0] REG_DIVIDER = 2'd1;
	localparam logic [1:0] REG_UPPER = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LIM0, S_LIM1, S_LIM2, S_LIM3, S_DIV, S_RANGE, S_SEARCH,
		S_IMUL, S_IDIV, S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

	function automatic logic [19:0] rom_ohm(input logic [IDX_W-1:0] i);
		logic [19:0] r;
		case (i)
			0: r = 20'd195652; 1: r = 20'd148171; 2: r = 20'd113347; 3: r = 20'd87559;
			4: r = 20'd68237; 5: r = 20'd53650; 6: r = 20'd42506; 7: r = 20'd33892;
			8: r = 20'd27219; 9: r = 20'd22021; 10: r = 20'd17926; 11: r = 20'd14674;
			12: r = 20'd12081; 13: r = 20'd10000; 14: r = 20'd8315; 15: r = 20'd6948;
			16: r = 20'd5834; 17: r = 20'd4917; 18: r = 20'd4161; 19: r = 20'd3535;
			20: r = 20'd3014; 21: r = 20'd2586; 22: r = 20'd2228; 23: r = 20'd1925;
			24: r = 20'd1669; 25: r = 20'd1452; 26: r = 20'd1268; 27: r = 20'd1110;
			28: r = 20'd974; 29: r = 20'd858; 30: r = 20'd758; 31: r = 20'd672;
			32: r = 20'd596; 33: r = 20'd531; 34: r = 20'd474; 35: r = 20'd424;
			36: r = 20'd381; 37: r = 20'd342; 38: r = 20'd309;
			default: r = 20'd309;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] rom_tdd(input logic [IDX_W-1:0] i);
		return 16'(-400 + 50 * int'(i));
	endfunction
endpackage

### design/ntc_divider.sv
// Restoring divider: one quotient bit per cycle, unsigned.
module ntc_divider import ntc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output div_ctl_t         ctl,
	output logic [NUM_W-1:0] quo
);
	logic [NUM_W-1:0] rem_q, den_q, quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic busy_q;
	logic [NUM_W:0] trial;

	assign trial = {rem_q, quo_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= QCNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == QCNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= NUM_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[NUM_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign quo = quo_q;
endmodule

### design/ntc_divider_adc_to_temperature_unit.sv
// Top level: NTC divider voltage to temperature converter.
// Path from request to m_tvalid: above limit ends after S_LIM1, below limit after S_LIM3, outside table
// after S_DIV and S_RANGE; interpolated adds S_SEARCH (k = segment index 0..37), S_IMUL and S_IDIV.
// Throughput: one request at a time; s_tready is high only in idle, the next request is taken
// at the earliest in the cycle after the result register loads.
// A result not taken holds the unit in its final state. Reset: async active low,
// registers return to 3300 mV, 10 kohm, NTC low; no result pending.
module ntc_divider_adc_to_temperature_unit import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // adc_mv
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // temperature[15:0], status[17:16], zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	state_t state_q, state_d;
	logic [15:0] supply_q, v_q;
	logic [19:0] rd_q;
	logic upper_q;
	logic [IDX_W-1:0] k_q;
	logic [RES_W-1:0] res_q;
	logic signed [15:0] t_q, m_t_q;
	logic [1:0] st_q, m_st_q;
	logic [NUM_W-1:0] mul_q, lhs_q;
	logic out_v_q;
	logic out_load;
	logic div_start;
	logic [NUM_W-1:0] div_num, div_den, quo;
	div_ctl_t dctl;
	logic [NUM_W-1:0] a_op, b_op;
	logic [NUM_W-1:0] prod;
	logic [19:0] rf, rl;
	logic [RES_W-1:0] rk1, dk;

	assign rf = rom_ohm(IDX_W'(0));
	assign rl = rom_ohm(IDX_W'(TABLE_ENTRIES - 1));
	assign rk1 = {rom_ohm(k_q + 1'b1), {FRAC_BITS{1'b0}}};
	assign dk = {rom_ohm(k_q) - rom_ohm(k_q + 1'b1), {FRAC_BITS{1'b0}}};
	assign out_load = (state_q == S_DONE) && (!out_v_q || m_tready);

	ntc_divider u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.ctl(dctl), .quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 16'd3300;
			rd_q <= 20'd10000;
			upper_q <= 1'b0;
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SUPPLY: supply_q <= cfg_data[15:0];
					REG_DIVIDER: rd_q <= cfg_data;
					REG_UPPER: upper_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_t_q <= t_q;
			m_st_q <= st_q;
		end
	end

	// shared multiplier operands (one product per cycle, combinational)
	always_comb begin
		a_op = '0;
		b_op = '0;
		unique case (state_q)
			S_LIM0: begin a_op = NUM_W'(v_q); b_op = NUM_W'(rd_q) + NUM_W'(upper_q ? rl : rf); end
			S_LIM1: begin a_op = NUM_W'(supply_q); b_op = NUM_W'(upper_q ? rd_q : rf); end
			S_LIM2: begin a_op = NUM_W'(v_q); b_op = NUM_W'(rd_q) + NUM_W'(upper_q ? rf : rl); end
			S_LIM3: begin a_op = NUM_W'(supply_q); b_op = NUM_W'(upper_q ? rd_q : rl); end
			default: ;
		endcase
	end
	assign prod = NUM_W'(a_op[21:0] * b_op[21:0]);

	always_comb begin
		logic [NUM_W-1:0] nm, dn;
		nm = '0;
		dn = '0;
		if (upper_q) begin
			nm = (supply_q > v_q) ? NUM_W'(rd_q * (supply_q - v_q)) : '0;
			dn = NUM_W'(v_q);
		end else begin
			nm = NUM_W'(rd_q * v_q);
			dn = (supply_q > v_q) ? NUM_W'(supply_q - v_q) : '0;
		end
		div_num = (state_q == S_IMUL) ? mul_q : NUM_W'(nm << FRAC_BITS);
		div_den = (state_q == S_IMUL) ? NUM_W'(dk) : dn;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: if (s_tvalid && s_tready) state_d = S_LIM0;
			S_LIM0: state_d = S_LIM1;
			S_LIM1: state_d = (lhs_q > prod) ? S_DONE : S_LIM2;
			S_LIM2: state_d = S_LIM3;
			S_LIM3: begin
				if (lhs_q < prod) state_d = S_DONE;
				else if (div_den == '0) state_d = S_RANGE;
				else begin div_start = 1'b1; state_d = S_DIV; end
			end
			S_DIV: if (!dctl.start && !dctl.busy) state_d = S_RANGE;
			S_RANGE: state_d = (res_q > {rf, {FRAC_BITS{1'b0}}} ||
				res_q < {rl, {FRAC_BITS{1'b0}}}) ? S_DONE : S_SEARCH;
			S_SEARCH: if (res_q >= rk1 || k_q == IDX_W'(TABLE_ENTRIES - 2)) state_d = S_IMUL;
			S_IMUL: begin div_start = 1'b1; state_d = S_IDIV; end
			S_IDIV: if (!dctl.start && !dctl.busy) state_d = S_DONE;
			S_DONE: if (!out_v_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin v_q <= s_tdata; k_q <= '0; end
			S_LIM0, S_LIM2: lhs_q <= prod;
			S_LIM3: res_q <= {RES_W{1'b1}};
			S_DIV: res_q <= (quo > NUM_W'({RES_W{1'b1}})) ? {RES_W{1'b1}} : quo[RES_W-1:0];
			S_SEARCH: begin
				if (!(res_q >= rk1 || k_q == IDX_W'(TABLE_ENTRIES - 2))) k_q <= k_q + 1'b1;
				// positive segments round the drop up so the sum truncates toward zero
				else mul_q <= NUM_W'(7'd50 * (res_q - rk1)) +
					((rom_tdd(k_q + 1'b1) > 16'sd0) ? NUM_W'(dk) - 1'b1 : '0);
			end
			default: ;
		endcase
		// result selection
		if (state_q == S_LIM1 && lhs_q > prod) begin
			t_q <= T_LOW_MARK; st_q <= ST_ABOVE;
		end
		if (state_q == S_LIM3 && lhs_q < prod) begin
			t_q <= T_HIGH_MARK; st_q <= ST_BELOW;
		end
		if (state_q == S_RANGE) begin
			t_q <= T_LOW_MARK; st_q <= ST_OUTSIDE;
		end
		if (state_q == S_IDIV && !dctl.start && !dctl.busy) begin
			t_q <= rom_tdd(k_q + 1'b1) - 16'(quo); st_q <= ST_OK;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {6'd0, m_st_q, m_t_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> m_tvalid) else $error("result lost");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
endmodule

### bench/tb_top.sv
// Testbench for the NTC divider voltage to temperature unit: directed table plus random requests.
`timescale 1ns / 1ps
module tb_top import ntc_pkg::*; ();

	typedef struct {
		logic [15:0] adc;
		bit          known;
		logic [15:0] t;
		logic [1:0]  st;
	} row_t;

	typedef struct {
		logic [15:0] t;
		logic [1:0]  st;
	} temp_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_SUPPLY;
	logic [19:0] cfg_data = '0;

	longint unsigned supply, divider, upper;
	temp_t           temp_q[$];
	bit              failed = 0;
	bit              hold_now = 0;
	longint          cycles = 0;

	int unsigned ohm_tab[39] = '{195652, 148171, 113347, 87559, 68237, 53650, 42506, 33892,
		27219, 22021, 17926, 14674, 12081, 10000, 8315, 6948, 5834, 4917, 4161, 3535,
		3014, 2586, 2228, 1925, 1669, 1452, 1268, 1110, 974, 858, 758, 672, 596, 531,
		474, 424, 381, 342, 309};

	row_t rows[14] = '{
		'{16'd0, 1, T_HIGH_MARK, ST_BELOW},
		'{16'd65535, 1, T_LOW_MARK, ST_ABOVE},
		'{16'd1650, 1, 16'd250, ST_OK},
		'{16'd3300, 1, T_LOW_MARK, ST_ABOVE},
		'{16'd98, 0, 0, 0}, '{16'd99, 0, 0, 0}, '{16'd3139, 0, 0, 0}, '{16'd3140, 0, 0, 0},
		'{16'd1, 0, 0, 0}, '{16'd1000, 0, 0, 0}, '{16'd2500, 0, 0, 0}, '{16'd3000, 0, 0, 0},
		'{16'h5555, 0, 0, 0}, '{16'haaaa, 0, 0, 0}
	};

	ntc_divider_adc_to_temperature_unit dut (.*);

	always #5 clk = ~clk;

	function automatic temp_t convert_mv(logic [15:0] adc);
		longint unsigned v, rf, rl, num, den, res, rmax;
		bit above, below;
		int k;
		longint rh, rlo, th, tl, d, t;
		temp_t o;
		v = adc;
		rf = ohm_tab[0];
		rl = ohm_tab[38];
		if (upper) begin
			above = v * (divider + rl) > supply * divider;
			below = v * (divider + rf) < supply * divider;
			num = (supply > v) ? divider * (supply - v) : 0;
			den = v;
		end else begin
			above = v * (rf + divider) > supply * rf;
			below = v * (rl + divider) < supply * rl;
			num = divider * v;
			den = (supply > v) ? supply - v : 0;
		end
		if (above) return '{T_LOW_MARK, ST_ABOVE};
		if (below) return '{T_HIGH_MARK, ST_BELOW};
		rmax = (64'd1 << (RES_INT_BITS + FRAC_BITS)) - 1;
		if (den == 0) res = rmax;
		else begin
			res = (num << FRAC_BITS) / den;
			if (res > rmax) res = rmax;
		end
		if (res > (rf << FRAC_BITS) || res < (rl << FRAC_BITS))
			return '{T_LOW_MARK, ST_OUTSIDE};
		for (k = 0; k < 37; k++)
			if (res >= (longint'(ohm_tab[k + 1]) << FRAC_BITS)) break;
		rh = longint'(ohm_tab[k]) << FRAC_BITS;
		rlo = longint'(ohm_tab[k + 1]) << FRAC_BITS;
		th = -400 + 50 * k;
		tl = th + 50;
		d = rh - rlo;
		if (d <= 0) t = tl;
		else t = (tl * d + (th - tl) * (longint'(res) - rlo)) / d;
		o.t = t[15:0];
		o.st = ST_OK;
		return o;
	endfunction

	task automatic write_reg(logic [1:0] idx, longint unsigned val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[19:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SUPPLY: supply = val & 16'hffff;
			REG_DIVIDER: divider = val & 20'hfffff;
			default: upper = val & 1;
		endcase
	endtask

	task automatic configure(longint unsigned vs, longint unsigned rd, longint unsigned up);
		wait (temp_q.size() == 0);
		repeat (150) @(posedge clk);
		write_reg(REG_SUPPLY, vs);
		write_reg(REG_DIVIDER, rd);
		write_reg(REG_UPPER, up);
	endtask

	task automatic send(logic [15:0] adc, bit known, temp_t exp_val);
		int gap;
		s_tvalid <= 1;
		s_tdata <= adc;
		do @(posedge clk); while (!s_tready);
		temp_q.push_back(known ? exp_val : convert_mv(adc));
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60));
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_mv();
		longint unsigned r, v;
		if ($urandom_range(0, 9) < 6) begin
			r = $urandom_range(300, 196000);
			if (upper) v = supply * divider / (divider + r);
			else v = supply * r / (r + divider);
			return v[15:0];
		end
		if ($urandom_range(0, 1)) return 16'($urandom_range(0, 32'(supply)));
		return 16'($urandom_range(0, 65535));
	endfunction

	always begin
		int n;
		if (hold_now) begin
			m_tready <= 0;
			repeat (400) @(posedge clk);
			hold_now = 0;
		end
		n = $urandom_range(0, 99);
		if (n < 60) begin
			m_tready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end else begin
			m_tready <= 0;
			repeat ((n < 93) ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		temp_t e;
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (temp_q.size() == 0) begin
				$error("unexpected request result %h", m_tdata);
				failed = 1;
			end else begin
				e = temp_q.pop_front();
				if (m_tdata[15:0] !== e.t) begin
					$error("temperature exp %0d got %0d",
						$signed(e.t), $signed(m_tdata[15:0]));
					failed = 1;
				end
				if (m_tdata[17:16] !== e.st) begin
					$error("status exp %0d got %0d", e.st, m_tdata[17:16]);
					failed = 1;
				end
			end
		end
	end

	initial begin
		longint unsigned cfgs[7][3] = '{'{3300, 10000, 1}, '{65535, 1000000, 0},
			'{1, 1, 1}, '{65535, 1, 1}, '{1, 1000000, 0}, '{5000, 4700, 1},
			'{3300, 10000, 0}};
		temp_t e;
		supply = 3300;
		divider = 10000;
		upper = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			e.t = rows[i].t;
			e.st = rows[i].st;
			send(rows[i].adc, rows[i].known, e);
		end
		s_tvalid <= 0;
		for (int p = 0; p < 7; p++) begin
			configure(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
			if (p == 0) hold_now = 1;
			repeat (40) send(pick_mv(), 0, e);
			s_tvalid <= 0;
		end
		for (int p = 0; p < 10; p++) begin
			configure($urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) :
				$urandom_range(1000, 24000),
				$urandom_range(0, 3) == 0 ? $urandom_range(1, 1000000) :
				$urandom_range(1000, 100000), $urandom_range(0, 1));
			repeat (50) send(pick_mv(), 0, e);
			s_tvalid <= 0;
		end
		wait (temp_q.size() == 0);
		repeat (150) @(posedge clk);
		if (!failed) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
